// ===== rtl/core/heq_pkg.sv =====
// Shared constants, codes and request types for the histogram equalizer.
`default_nettype none
package heq_pkg;

    localparam int BINS       = 256;
    localparam int PIX_W      = 8;
    localparam int MODE_W     = 2;
    localparam int MAX_PIXELS = 4194304;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int NUM_W      = CNT_W + PIX_W;
    localparam int STEP_W     = $clog2(PIX_W);

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_MAP   = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT,
        S_BRD,
        S_BACC,
        S_BMUL,
        S_BDIV,
        S_MAPRQ,
        S_MAPRD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             clr;
        logic             rd_en;
        logic [PIX_W-1:0] rd_addr;
        logic             wr_en;
        logic [PIX_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
    } bin_req_t;

    typedef struct packed {
        logic             rd_en;
        logic [PIX_W-1:0] rd_addr;
        logic             wr_en;
        logic [PIX_W-1:0] wr_addr;
        logic [PIX_W-1:0] wr_data;
    } map_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/histogram_equalizer.sv =====
// Histogram equalizer top level: command sequencer, table rebuild and result register.
//
//  channel | dir | beat contents
//  s_*     | in  | tuser = mode[1:0], tdata = pixel[7:0]
//  m_*     | out | tdata = mapped_pixel[7:0], tuser = no_data
//
// Clear empties the bins and total when accepted. Count reads the bin, then writes it back.
// Map with a current table reads the table, then emits; map with nothing counted emits no_data.
// First map after a clear or count rebuilds the table bin by bin, through the bin memory
// read, the accumulate and the 8-step divider.
// Reset clears the histogram flags and total at once; a waiting result holds input off
// only while it cannot be moved into the output register.
`default_nettype none
module histogram_equalizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] pixel
    input  wire logic [1:0] s_tuser,   // [1:0] mode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] mapped_pixel
    output logic            m_tuser    // [0] no_data
);
    import heq_pkg::*;

    state_t           state_reg,   state_next;
    logic [PIX_W-1:0] pix_reg,     pix_next;
    logic [PIX_W-1:0] idx_reg,     idx_next;
    logic [CNT_W-1:0] run_reg,     run_next;
    logic [CNT_W-1:0] total_reg,   total_next;
    logic             tv_reg,      tv_next;
    logic [PIX_W-1:0] res_pix_reg, res_pix_next;
    logic             res_nd_reg,  res_nd_next;
    logic             out_vld_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_nd_reg;
    logic             load_out;
    logic             out_free;

    bin_req_t         bin_req;
    map_req_t         map_req;
    logic [CNT_W-1:0] bin_rd;
    logic [PIX_W-1:0] map_rd;
    logic             div_start;
    logic             div_done;
    logic [PIX_W-1:0] div_quot;
    logic [NUM_W-1:0] numer;

    heq_bin_mem u_bins (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (bin_req),
        .rd_data (bin_rd)
    );

    heq_map_mem u_map (
        .clk     (clk),
        .req     (map_req),
        .rd_data (map_rd)
    );

    // running * 255 as a shift and subtract
    assign numer = (NUM_W'(run_reg) << PIX_W) - NUM_W'(run_reg);

    heq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer),
        .denom (total_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_free = !out_vld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            tv_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            tv_reg    <= tv_next;
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg     <= pix_next;
        idx_reg     <= idx_next;
        run_reg     <= run_next;
        res_pix_reg <= res_pix_next;
        res_nd_reg  <= res_nd_next;
        if (load_out)
        begin
            out_pix_reg <= res_pix_reg;
            out_nd_reg  <= res_nd_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pix_next     = pix_reg;
        idx_next     = idx_reg;
        run_next     = run_reg;
        total_next   = total_reg;
        tv_next      = tv_reg;
        res_pix_next = res_pix_reg;
        res_nd_next  = res_nd_reg;
        bin_req      = '0;
        map_req      = '0;
        div_start    = 1'b0;
        load_out     = 1'b0;
        s_tready     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (mode_t'(s_tuser))
                        MODE_CLEAR:
                        begin
                            bin_req.clr = 1'b1;
                            total_next  = '0;
                            tv_next     = 1'b0;
                        end
                        MODE_COUNT:
                        begin
                            tv_next = 1'b0;
                            if (total_reg < CNT_W'(MAX_PIXELS))
                            begin
                                bin_req.rd_en   = 1'b1;
                                bin_req.rd_addr = s_tdata;
                                pix_next        = s_tdata;
                                state_next      = S_CNT;
                            end
                        end
                        MODE_MAP:
                        begin
                            pix_next = s_tdata;
                            if (total_reg == '0)
                            begin
                                res_pix_next = '0;
                                res_nd_next  = 1'b1;
                                state_next   = S_EMIT;
                            end
                            else if (tv_reg)
                            begin
                                map_req.rd_en   = 1'b1;
                                map_req.rd_addr = s_tdata;
                                state_next      = S_MAPRD;
                            end
                            else
                            begin
                                idx_next   = '0;
                                run_next   = '0;
                                state_next = S_BRD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CNT:
            begin
                bin_req.wr_en   = 1'b1;
                bin_req.wr_addr = pix_reg;
                bin_req.wr_data = bin_rd + 1'b1;
                total_next      = total_reg + 1'b1;
                state_next      = S_IDLE;
            end
            S_BRD:
            begin
                bin_req.rd_en   = 1'b1;
                bin_req.rd_addr = idx_reg;
                state_next      = S_BACC;
            end
            S_BACC:
            begin
                run_next   = run_reg + bin_rd;
                state_next = S_BMUL;
            end
            S_BMUL:
            begin
                div_start  = 1'b1;
                state_next = S_BDIV;
            end
            S_BDIV:
            begin
                if (div_done)
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = idx_reg;
                    map_req.wr_data = div_quot;
                    if (idx_reg == PIX_W'(BINS - 1))
                    begin
                        tv_next    = 1'b1;
                        state_next = S_MAPRQ;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_BRD;
                    end
                end
            end
            S_MAPRQ:
            begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = pix_reg;
                state_next      = S_MAPRD;
            end
            S_MAPRD:
            begin
                res_pix_next = map_rd;
                res_nd_next  = 1'b0;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tuser  = out_nd_reg;

endmodule
`default_nettype wire

// ===== rtl/core/heq_bin_mem.sv =====
// Histogram bin memory with per-bin valid flags, so that one clear request empties every bin.
`default_nettype none
module heq_bin_mem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire heq_pkg::bin_req_t         req,
    output logic [heq_pkg::CNT_W-1:0]      rd_data
);
    import heq_pkg::*;

    logic [CNT_W-1:0] mem [BINS];
    logic [BINS-1:0]  vld_reg;
    logic [CNT_W-1:0] data_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    // bins never written since the last clear read as zero
    assign rd_data = hit_reg ? data_reg : '0;

endmodule
`default_nettype wire

// ===== rtl/core/heq_map_mem.sv =====
// Equalization lookup table memory.
`default_nettype none
module heq_map_mem (
    input  wire logic                      clk,
    input  wire heq_pkg::map_req_t         req,
    output logic [heq_pkg::PIX_W-1:0]      rd_data
);
    import heq_pkg::*;

    logic [PIX_W-1:0] mem [BINS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/heq_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient known to fit PIX_W bits.
`default_nettype none
module heq_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [heq_pkg::NUM_W-1:0] numer,
    input  wire logic [heq_pkg::CNT_W-1:0] denom,
    output logic                           done,
    output logic [heq_pkg::PIX_W-1:0]      quot
);
    import heq_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [PIX_W-1:0]  quot_reg;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(PIX_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= numer;
            dsh_reg  <= NUM_W'(denom) << (PIX_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[PIX_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire
